@@ rtl/zcbm_pkg.sv @@
package zcbm_pkg;
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT_ROW,
        ST_SCAN,
        ST_STEP,
        ST_AUG,
        ST_REACH_INIT,
        ST_REACH_COL,
        ST_REACH_ROW,
        ST_DONE
    } t_state;
endpackage

@@ rtl/zero_cover_by_matching_top.sv @@
// Order: n*n words are loaded, then the matching search runs, then reach marking,
// then one done state; the strobe follows.
// Throughput: one word per cycle while start is high and i_cfg_we low during load;
// busy is high outside ST_LOAD; search: one shared column scan step per cycle.
// Reset (synchronous, active low) clears matching state and load count, and sets size 16.
// The receiver cannot stall: the o_valid strobe is shown for exactly one cycle.
module zero_cover_by_matching_top #(
    parameter int MAX_SIZE = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [31:0] i_entry_value,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    output logic        o_valid,
    output logic [15:0] o_row_cover,
    output logic [15:0] o_column_cover,
    output logic [4:0]  o_matching_size,
    output logic        o_cover_trivial
);
    import zcbm_pkg::*;

    localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int CW = $clog2(MAX_SIZE + 1);
    localparam int DW = $clog2(MAX_SIZE + 1);

    t_state r_state, n_state;
    logic [MAX_SIZE-1:0] r_zmap [MAX_SIZE];
    logic [IW-1:0] r_cmatch [MAX_SIZE];
    logic [MAX_SIZE-1:0] r_mvalid, r_seen, r_rreach, r_creach;
    logic [IW-1:0] r_srow [MAX_SIZE+1];
    logic [IW-1:0] r_scol [MAX_SIZE+1];
    logic [DW-1:0] r_depth;
    logic [CW-1:0] r_j;
    logic [IW-1:0] r_lrow, r_lcol, r_row;
    logic [4:0]    r_size;
    logic [CW-1:0] w_n;
    logic [MAX_SIZE-1:0] w_full;
    logic          r_chg;
    logic [IW-1:0] r_k;

    always_comb begin
        if (r_size == 5'd0) w_n = CW'(1);
        else if (32'(r_size) > MAX_SIZE) w_n = CW'(MAX_SIZE);
        else w_n = CW'(r_size);
    end

    always_comb begin
        for (int i = 0; i < MAX_SIZE; i++) w_full[i] = (i < 32'(w_n));
    end

    logic w_hit, w_last_cell, w_jend, w_rowend, w_row_hit;
    logic [IW-1:0] w_jc;
    assign w_jc = r_j[IW-1:0];
    assign w_jend = (r_j >= w_n);
    assign w_hit = !w_jend && r_zmap[r_srow[r_depth]][w_jc] && !r_seen[w_jc];
    assign w_last_cell = (CW'(r_lrow) == w_n - CW'(1)) && (CW'(r_lcol) == w_n - CW'(1));
    assign w_rowend = (CW'(r_k) == w_n - CW'(1));
    assign w_row_hit = r_creach[r_k] && r_mvalid[r_k] && !r_rreach[r_cmatch[r_k]];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD:       if (start && !i_cfg_we && w_last_cell) n_state = ST_INIT_ROW;
            ST_INIT_ROW:   n_state = ST_SCAN;
            ST_SCAN: begin
                if (w_jend || 32'(r_depth) >= MAX_SIZE) n_state = ST_STEP;
                else if (w_hit && !r_mvalid[w_jc]) n_state = ST_AUG;
            end
            ST_STEP: begin
                if (r_depth == '0) begin
                    if (CW'(r_row) == w_n - CW'(1)) n_state = ST_REACH_INIT;
                    else n_state = ST_INIT_ROW;
                end else n_state = ST_SCAN;
            end
            ST_AUG: begin
                if (r_depth == '0) begin
                    if (CW'(r_row) == w_n - CW'(1)) n_state = ST_REACH_INIT;
                    else n_state = ST_INIT_ROW;
                end
            end
            ST_REACH_INIT: n_state = ST_REACH_COL;
            ST_REACH_COL:  if (w_rowend) n_state = ST_REACH_ROW;
            ST_REACH_ROW: begin
                if (w_rowend) n_state = (r_chg || w_row_hit) ? ST_REACH_COL : ST_DONE;
            end
            ST_DONE:       n_state = ST_LOAD;
            default:       n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        busy = (r_state != ST_LOAD);
    end

    logic [MAX_SIZE-1:0] w_matched;
    always_comb begin
        w_matched = '0;
        for (int c = 0; c < MAX_SIZE; c++)
            if (r_mvalid[c] && w_full[c]) w_matched[r_cmatch[c]] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_size <= 5'd16;
            r_lrow <= '0;
            r_lcol <= '0;
            r_mvalid <= '0;
            r_seen <= '0;
            r_rreach <= '0;
            r_creach <= '0;
            r_depth <= '0;
            r_j <= '0;
            r_row <= '0;
            r_k <= '0;
            r_chg <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                r_size <= i_cfg_data;
                r_lrow <= '0;
                r_lcol <= '0;
            end
            unique case (r_state)
                ST_LOAD: begin
                    if (start && !i_cfg_we) begin
                        r_zmap[r_lrow][r_lcol] <= (i_entry_value == 32'sd0);
                        if (CW'(r_lcol) == w_n - CW'(1)) begin
                            r_lcol <= '0;
                            r_lrow <= w_last_cell ? '0 : r_lrow + IW'(1);
                        end else r_lcol <= r_lcol + IW'(1);
                        if (w_last_cell) begin
                            r_mvalid <= '0;
                            r_row <= '0;
                        end
                    end
                end
                ST_INIT_ROW: begin
                    r_seen <= '0;
                    r_depth <= '0;
                    r_srow[0] <= r_row;
                    r_j <= '0;
                end
                ST_SCAN: begin
                    if (w_jend || 32'(r_depth) >= MAX_SIZE) begin
                        r_j <= r_j;
                    end else if (w_hit) begin
                        r_seen[w_jc] <= 1'b1;
                        r_scol[r_depth] <= w_jc;
                        if (r_mvalid[w_jc]) begin
                            r_depth <= r_depth + DW'(1);
                            r_srow[r_depth + DW'(1)] <= r_cmatch[w_jc];
                            r_j <= '0;
                        end
                    end else r_j <= r_j + CW'(1);
                end
                ST_STEP: begin
                    if (r_depth == '0) begin
                        r_row <= r_row + IW'(1);
                    end else begin
                        r_depth <= r_depth - DW'(1);
                        r_j <= CW'(r_scol[r_depth - DW'(1)]) + CW'(1);
                    end
                end
                ST_AUG: begin
                    r_cmatch[r_scol[r_depth]] <= r_srow[r_depth];
                    r_mvalid[r_scol[r_depth]] <= 1'b1;
                    if (r_depth == '0) r_row <= r_row + IW'(1);
                    else r_depth <= r_depth - DW'(1);
                end
                ST_REACH_INIT: begin
                    r_rreach <= ~w_matched & w_full;
                    r_creach <= '0;
                    r_k <= '0;
                    r_chg <= 1'b0;
                end
                ST_REACH_COL: begin
                    if (r_rreach[r_k] && ((r_zmap[r_k] & w_full & ~r_creach) != '0)) begin
                        r_creach <= r_creach | (r_zmap[r_k] & w_full);
                        r_chg <= 1'b1;
                    end
                    r_k <= w_rowend ? '0 : r_k + IW'(1);
                end
                ST_REACH_ROW: begin
                    if (w_row_hit) r_rreach[r_cmatch[r_k]] <= 1'b1;
                    r_k <= w_rowend ? '0 : r_k + IW'(1);
                    r_chg <= w_rowend ? 1'b0 : (r_chg | w_row_hit);
                end
                ST_DONE: begin
                    o_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    logic [MAX_SIZE-1:0] w_rows, w_cols;
    logic [4:0] w_cnt;
    assign w_rows = ~r_rreach & w_full;
    assign w_cols = r_creach & w_full;
    always_comb begin
        w_cnt = '0;
        for (int c = 0; c < MAX_SIZE; c++) w_cnt = w_cnt + 5'(r_mvalid[c] & w_full[c]);
    end
    always_comb begin
        o_row_cover = 16'(w_rows);
        o_column_cover = 16'(w_cols);
        o_matching_size = w_cnt;
        o_cover_trivial = (w_rows == w_full) || (w_cols == w_full);
    end

`ifndef SYNTHESIS
    a_valid_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == ST_DONE) else $error("strobe without done");
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("strobe while busy");
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_depth) <= MAX_SIZE) else $error("stack overflow");
`endif
endmodule
